// ----- hw/rtl/ccta_pkg.sv -----
package ccta_pkg;

  localparam int SIZE_BITS_DEF  = 20;
  // start code must begin at one of the first few byte positions
  localparam int SCAN_POSITIONS = 4;
  localparam logic [4:0] MIN_SCAN_LEN = 5'd4;
  localparam logic [4:0] POS_MAX      = 5'd31;

  localparam logic [7:0] MARKER   = 8'h01;
  localparam logic [7:0] SPS_MASK = 8'h1f;
  localparam logic [7:0] LEN_MASK = 8'h03;

  localparam logic [4:0] AVC_LEN_POS = 5'd4;
  localparam logic [4:0] AVC_SPS_POS = 5'd5;
  localparam logic [4:0] HVC_LEN_POS = 5'd21;
  localparam logic [4:0] HVC_ARR_POS = 5'd22;

  localparam logic [2:0] LEN_SIZE_DEF = 3'd4;

  localparam logic [1:0] KIND_AVC  = 2'd0;
  localparam logic [1:0] KIND_HVC  = 2'd1;
  localparam logic [1:0] KIND_PASS = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSTART = 2'd1;
  localparam logic [1:0] STAT_TRUNC   = 2'd2;

  typedef enum logic [11:0] {
    PH_START      = 12'b0000_0000_0001,
    PH_HDR        = 12'b0000_0000_0010,
    PH_PPS_COUNT  = 12'b0000_0000_0100,
    PH_ARRAY_TYPE = 12'b0000_0000_1000,
    PH_NUM_HI     = 12'b0000_0001_0000,
    PH_NUM_LO     = 12'b0000_0010_0000,
    PH_LEN_HI     = 12'b0000_0100_0000,
    PH_LEN_LO     = 12'b0000_1000_0000,
    PH_NAL_DATA   = 12'b0001_0000_0000,
    PH_FINISHED   = 12'b0010_0000_0000,
    PH_SCAN       = 12'b0100_0000_0000,
    PH_PASS       = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       done_res;
    logic [2:0] size_length;
    logic [1:0] status;
  } ccta_res_t;

endpackage

// ----- hw/rtl/ccta_in_reg.sv -----
module ccta_in_reg
  import ccta_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte
  input  logic       s_tlast,   // last_byte
  input  logic       consume,
  output logic       item_valid,
  output logic [7:0] item_byte,
  output logic       item_last
);

  logic accept;

  assign s_tready = !item_valid || consume;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (consume) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_byte <= s_tdata;
      item_last <= s_tlast;
    end
  end

endmodule

// ----- hw/rtl/ccta_parser.sv -----
module ccta_parser
  import ccta_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_data,
  input  logic                 item_valid,
  input  logic [7:0]           item_byte,
  input  logic                 item_last,
  input  logic                 res_slot,
  output logic                 consume,
  output logic                 res_load,
  output ccta_res_t            res,
  output logic [SIZE_BITS-1:0] res_total
);

  logic [1:0]           kind;
  phase_t               phase, phase_next;
  logic [4:0]           pos, pos_next;
  logic [7:0]           arrays_left, arrays_left_next;
  logic [15:0]          nalus_left, nalus_left_next;
  logic [15:0]          nal_bytes_left, nal_bytes_left_next;
  logic [7:0]           length_high, length_high_next;
  logic                 in_pps, in_pps_next;
  logic [2:0]           len_size, len_size_next;
  logic [SIZE_BITS-1:0] count, count_next;
  logic [15:0]          recent, recent_next;
  logic                 start_found, start_found_next;
  logic                 hevc, hevc_next;
  logic [1:0]           sc_idx;

  logic       fire;
  logic       step_done;
  logic       emit;
  logic [7:0] emit_byte;
  logic       nal_end;
  logic       arr_end;
  logic [15:0] nalus_dec;
  logic [7:0]  arrays_dec;
  logic [1:0]  st;
  logic        kind_parsed;

  assign fire        = item_valid && res_slot;
  assign nalus_dec   = nalus_left - 16'd1;
  assign arrays_dec  = arrays_left - 8'd1;
  assign kind_parsed = (kind == KIND_AVC) || (kind == KIND_HVC);

  always_comb begin
    phase_next          = phase;
    pos_next            = (pos != POS_MAX) ? pos + 5'd1 : pos;
    arrays_left_next    = arrays_left;
    nalus_left_next     = nalus_left;
    nal_bytes_left_next = nal_bytes_left;
    length_high_next    = length_high;
    in_pps_next         = in_pps;
    len_size_next       = len_size;
    recent_next         = recent;
    start_found_next    = start_found;
    hevc_next           = hevc;
    step_done           = 1'b1;
    emit                = 1'b0;
    emit_byte           = item_byte;
    nal_end             = 1'b0;
    arr_end             = 1'b0;

    case (phase)
      PH_START: begin
        if (kind_parsed && item_byte == MARKER) begin
          phase_next = PH_HDR;
          hevc_next  = (kind == KIND_HVC);
        end else if (kind_parsed) begin
          phase_next  = PH_SCAN;
          emit        = 1'b1;
          recent_next = {recent[7:0], item_byte};
        end else begin
          phase_next = PH_PASS;
          emit       = 1'b1;
        end
      end
      PH_SCAN: begin
        emit = 1'b1;
        if (pos >= 5'd2 && pos <= 5'(SCAN_POSITIONS + 1) && recent == 16'd0 &&
            item_byte == MARKER) begin
          start_found_next = 1'b1;
        end
        recent_next = {recent[7:0], item_byte};
      end
      PH_PASS: begin
        emit = 1'b1;
      end
      PH_HDR: begin
        if (!hevc) begin
          if (pos == AVC_LEN_POS) begin
            len_size_next = 3'(item_byte & LEN_MASK) + 3'd1;
          end else if (pos == AVC_SPS_POS) begin
            nalus_left_next = {8'd0, item_byte & SPS_MASK};
            in_pps_next     = 1'b0;
            phase_next      = ((item_byte & SPS_MASK) != 8'd0) ? PH_LEN_HI : PH_PPS_COUNT;
          end
        end else begin
          if (pos == HVC_LEN_POS) begin
            len_size_next = 3'(item_byte & LEN_MASK) + 3'd1;
          end else if (pos == HVC_ARR_POS) begin
            arrays_left_next = item_byte;
            phase_next       = (item_byte != 8'd0) ? PH_ARRAY_TYPE : PH_FINISHED;
          end
        end
      end
      PH_PPS_COUNT: begin
        nalus_left_next = {8'd0, item_byte};
        in_pps_next     = 1'b1;
        phase_next      = (item_byte != 8'd0) ? PH_LEN_HI : PH_FINISHED;
      end
      PH_ARRAY_TYPE: begin
        phase_next = PH_NUM_HI;
      end
      PH_NUM_HI: begin
        length_high_next = item_byte;
        phase_next       = PH_NUM_LO;
      end
      PH_NUM_LO: begin
        nalus_left_next = {length_high, item_byte};
        if ({length_high, item_byte} != 16'd0) begin
          phase_next = PH_LEN_HI;
        end else begin
          arr_end = 1'b1;
        end
      end
      PH_LEN_HI: begin
        length_high_next = item_byte;
        phase_next       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        // the four start code bytes go out one at a time, the length byte is held until the last
        emit                = 1'b1;
        emit_byte           = (sc_idx == 2'd3) ? 8'h01 : 8'h00;
        step_done           = (sc_idx == 2'd3);
        nal_bytes_left_next = {length_high, item_byte};
        if ({length_high, item_byte} != 16'd0) begin
          phase_next = PH_NAL_DATA;
        end else begin
          nal_end = 1'b1;
        end
      end
      PH_NAL_DATA: begin
        emit                = 1'b1;
        nal_bytes_left_next = nal_bytes_left - 16'd1;
        if (nal_bytes_left == 16'd1) begin
          nal_end = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (nal_end) begin
      nalus_left_next = nalus_dec;
      if (nalus_dec != 16'd0) begin
        phase_next = PH_LEN_HI;
      end else if (hevc) begin
        arr_end = 1'b1;
      end else if (!in_pps) begin
        phase_next = PH_PPS_COUNT;
      end else begin
        phase_next = PH_FINISHED;
      end
    end
    if (arr_end) begin
      arrays_left_next = arrays_dec;
      phase_next       = (arrays_dec != 8'd0) ? PH_ARRAY_TYPE : PH_FINISHED;
    end
  end

  always_comb begin
    count_next = count;
    if (emit && count != {SIZE_BITS{1'b1}}) begin
      count_next = count + 1'b1;
    end
  end

  always_comb begin
    if (phase_next == PH_SCAN) begin
      st = (start_found_next && pos_next >= MIN_SCAN_LEN) ? STAT_OK : STAT_NOSTART;
    end else if (phase_next == PH_PASS || phase_next == PH_FINISHED) begin
      st = STAT_OK;
    end else if (phase_next == PH_HDR && pos_next == 5'd1) begin
      st = STAT_OK;
    end else begin
      st = STAT_TRUNC;
    end
  end

  assign consume  = fire && step_done;
  assign res_load = fire && (emit || (item_last && step_done));

  always_comb begin
    res.out_byte    = emit ? emit_byte : 8'd0;
    res.byte_valid  = emit;
    res.done_res    = item_last && step_done;
    res.size_length = len_size_next;
    res.status      = (item_last && step_done) ? st : STAT_OK;
  end
  assign res_total = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= KIND_AVC;
    end else if (cfg_valid) begin
      kind <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (consume && item_last)) begin
      phase          <= PH_START;
      pos            <= 5'd0;
      arrays_left    <= 8'd0;
      nalus_left     <= 16'd0;
      nal_bytes_left <= 16'd0;
      length_high    <= 8'd0;
      in_pps         <= 1'b0;
      len_size       <= LEN_SIZE_DEF;
      count          <= '0;
      recent         <= 16'd0;
      start_found    <= 1'b0;
      hevc           <= 1'b0;
      sc_idx         <= 2'd0;
    end else if (fire) begin
      count <= count_next;
      if (step_done) begin
        sc_idx         <= 2'd0;
        phase          <= phase_next;
        pos            <= pos_next;
        arrays_left    <= arrays_left_next;
        nalus_left     <= nalus_left_next;
        nal_bytes_left <= nal_bytes_left_next;
        length_high    <= length_high_next;
        in_pps         <= in_pps_next;
        len_size       <= len_size_next;
        recent         <= recent_next;
        start_found    <= start_found_next;
        hevc           <= hevc_next;
      end else begin
        sc_idx <= sc_idx + 2'd1;
      end
    end
  end

endmodule

// ----- hw/rtl/ccta_out_reg.sv -----
module ccta_out_reg
  import ccta_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF,
  parameter int TDATA_W   = ((SIZE_BITS + 13 + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 res_load,
  input  ccta_res_t            res,
  input  logic [SIZE_BITS-1:0] res_total,
  output logic                 res_slot,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [TDATA_W-1:0]   m_tdata,
  output logic                 m_tuser,
  output logic                 m_tlast
);

  ccta_res_t            held;
  logic [SIZE_BITS-1:0] held_total;

  assign res_slot = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      held       <= res;
      held_total <= res_total;
    end
  end

  always_comb begin
    m_tdata                 = '0;
    m_tdata[SIZE_BITS+12:0] = {held.status, held_total, held.size_length, held.out_byte};
  end
  assign m_tuser = held.byte_valid;
  assign m_tlast = held.done_res;

endmodule

// ----- hw/rtl/codec_config_to_annexb.sv -----
// an accepted byte passes through the input register and the parser into the output register
// throughput: one byte per cycle unless the output stalls; a NAL length byte
//   holds the input while the start code goes out, one start code byte per cycle
// the output register takes a new result whenever the current one is transferred
// reset: synchronous, active high; clears the parser to start of record,
//   codec_kind to H.264 and empties both registers
module codec_config_to_annexb
  import ccta_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF,
  localparam int TDATA_W  = ((SIZE_BITS + 13 + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data,   // codec_kind
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,    // data_byte
  input  logic               s_tlast,    // last_byte
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,    // out_byte, size_length, total_size, status
  output logic               m_tuser,    // byte_valid
  output logic               m_tlast     // done_res
);

  logic                 consume;
  logic                 item_valid;
  logic [7:0]           item_byte;
  logic                 item_last;
  logic                 res_slot;
  logic                 res_load;
  ccta_res_t            res;
  logic [SIZE_BITS-1:0] res_total;

  assign cfg_ready = 1'b1;

  ccta_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .consume    (consume),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .item_last  (item_last)
  );

  ccta_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .item_last  (item_last),
    .res_slot   (res_slot),
    .consume    (consume),
    .res_load   (res_load),
    .res        (res),
    .res_total  (res_total)
  );

  ccta_out_reg #(
    .SIZE_BITS (SIZE_BITS),
    .TDATA_W   (TDATA_W)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res       (res),
    .res_total (res_total),
    .res_slot  (res_slot),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ----- hw/rtl/ccta_checker.sv -----
module ccta_props
  import ccta_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF,
  localparam int TDATA_W  = ((SIZE_BITS + 13 + 7) / 8) * 8
) (
  input logic               clk,
  input logic               rst,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic               m_tuser,
  input logic               m_tlast
);

  logic [1:0] st;
  logic [2:0] len_size;

  assign st       = m_tdata[SIZE_BITS+12:SIZE_BITS+11];
  assign len_size = m_tdata[10:8];

  // nothing left on the output after a reset cycle
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  // status is reported only on the final result of a record
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> st == STAT_OK)
    else $error("nonzero status before end of record");

  // a filler result without a valid output byte only closes a record
  a_filler_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && m_tdata[7:0] == 8'd0)
    else $error("filler result not at end of record");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> len_size != 3'd0 && len_size <= 3'd4)
    else $error("length size out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output transfer changed");

endmodule

bind codec_config_to_annexb ccta_props #(.SIZE_BITS(SIZE_BITS)) u_ccta_props (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ----- test/ccta_checker.sv -----
`timescale 1ns / 1ps

module ccta_checker
  import ccta_pkg::*;
#(
  parameter int TDATA_W = 40
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_data,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [7:0]         s_tdata,
  input  logic               s_tlast,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [TDATA_W-1:0] m_tdata,
  input  logic               m_tuser,
  input  logic               m_tlast,
  output int                 errors,
  output int                 pending
);

  localparam logic [7:0] SC_ONE = 8'h01;
  localparam logic [SIZE_BITS_DEF-1:0] TOTAL_MAX = '1;

  // m_tdata layout, lowest bit up
  localparam int LEN_LSB   = 8;
  localparam int TOTAL_LSB = LEN_LSB + 3;
  localparam int STAT_LSB  = TOTAL_LSB + SIZE_BITS_DEF;

  typedef struct {
    logic [7:0]               out_byte;
    logic                     byte_valid;
    logic                     done_res;
    logic [2:0]               size_length;
    logic [SIZE_BITS_DEF-1:0] total_size;
    logic [1:0]               status;
  } annexb_out_t;

  annexb_out_t annexb_q[$];
  annexb_out_t step_q[$];

  logic [1:0]               kind_reg;
  phase_t                   ph;
  logic [4:0]               pos;
  logic [7:0]               arrays_left;
  logic [15:0]              nalus_left;
  logic [15:0]              nal_bytes_left;
  logic [7:0]               length_high;
  logic                     in_pps;
  logic                     hevc_rec;
  logic                     start_found;
  logic [2:0]               len_size;
  logic [SIZE_BITS_DEF-1:0] emitted;
  logic [15:0]              recent;

  function automatic void clear_record();
    ph             = PH_START;
    pos            = '0;
    arrays_left    = '0;
    nalus_left     = '0;
    nal_bytes_left = '0;
    length_high    = '0;
    in_pps         = 1'b0;
    hevc_rec       = 1'b0;
    start_found    = 1'b0;
    len_size       = LEN_SIZE_DEF;
    emitted        = '0;
    recent         = '0;
  endfunction

  function automatic void emit_byte(logic [7:0] b, logic v);
    annexb_out_t r;
    if (v && emitted != TOTAL_MAX) emitted++;
    r.out_byte    = b;
    r.byte_valid  = v;
    r.done_res    = 1'b0;
    r.size_length = len_size;
    r.total_size  = emitted;
    r.status      = STAT_OK;
    step_q.push_back(r);
  endfunction

  function automatic void array_done();
    arrays_left = arrays_left - 8'd1;
    ph = (arrays_left != 0) ? PH_ARRAY_TYPE : PH_FINISHED;
  endfunction

  function automatic void nal_done();
    nalus_left = nalus_left - 16'd1;
    if (nalus_left != 0) ph = PH_LEN_HI;
    else if (hevc_rec) array_done();
    else if (!in_pps) ph = PH_PPS_COUNT;
    else ph = PH_FINISHED;
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic last);
    logic [4:0]  p;
    logic [1:0]  st;
    annexb_out_t r;
    p = pos;
    step_q.delete();
    case (ph)
      PH_START: begin
        if (kind_reg <= KIND_HVC && b == MARKER) begin
          ph = PH_HDR;
          hevc_rec = (kind_reg == KIND_HVC);
        end else if (kind_reg <= KIND_HVC) begin
          ph = PH_SCAN;
          emit_byte(b, 1'b1);
          recent = {recent[7:0], b};
        end else begin
          ph = PH_PASS;
          emit_byte(b, 1'b1);
        end
      end
      PH_SCAN: begin
        emit_byte(b, 1'b1);
        if (p >= 2 && (int'(p) - 2) < SCAN_POSITIONS && recent == 16'h0000 && b == SC_ONE)
          start_found = 1'b1;
        recent = {recent[7:0], b};
      end
      PH_PASS: emit_byte(b, 1'b1);
      PH_HDR: begin
        if (!hevc_rec) begin
          if (p == AVC_LEN_POS) begin
            len_size = 3'(b & LEN_MASK) + 3'd1;
          end else if (p == AVC_SPS_POS) begin
            nalus_left = {8'h00, b & SPS_MASK};
            in_pps = 1'b0;
            ph = (nalus_left != 0) ? PH_LEN_HI : PH_PPS_COUNT;
          end
        end else begin
          if (p == HVC_LEN_POS) begin
            len_size = 3'(b & LEN_MASK) + 3'd1;
          end else if (p == HVC_ARR_POS) begin
            arrays_left = b;
            ph = (b != 0) ? PH_ARRAY_TYPE : PH_FINISHED;
          end
        end
      end
      PH_PPS_COUNT: begin
        nalus_left = {8'h00, b};
        in_pps = 1'b1;
        ph = (b != 0) ? PH_LEN_HI : PH_FINISHED;
      end
      PH_ARRAY_TYPE: ph = PH_NUM_HI;
      PH_NUM_HI: begin
        length_high = b;
        ph = PH_NUM_LO;
      end
      PH_NUM_LO: begin
        nalus_left = {length_high, b};
        if (nalus_left != 0) ph = PH_LEN_HI;
        else array_done();
      end
      PH_LEN_HI: begin
        length_high = b;
        ph = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        nal_bytes_left = {length_high, b};
        emit_byte(8'h00, 1'b1);
        emit_byte(8'h00, 1'b1);
        emit_byte(8'h00, 1'b1);
        emit_byte(SC_ONE, 1'b1);
        if (nal_bytes_left != 0) ph = PH_NAL_DATA;
        else nal_done();
      end
      PH_NAL_DATA: begin
        emit_byte(b, 1'b1);
        nal_bytes_left = nal_bytes_left - 16'd1;
        if (nal_bytes_left == 0) nal_done();
      end
      default: ;  // list finished, byte dropped
    endcase

    if (pos < POS_MAX) pos++;

    if (last) begin
      if (step_q.size() == 0) emit_byte(8'h00, 1'b0);
      if (ph == PH_SCAN) st = (start_found && pos >= MIN_SCAN_LEN) ? STAT_OK : STAT_NOSTART;
      else if (ph == PH_PASS || ph == PH_FINISHED) st = STAT_OK;
      else if (ph == PH_HDR && pos == 5'd1) st = STAT_OK;  // lone marker byte
      else st = STAT_TRUNC;
      r = step_q[step_q.size()-1];
      r.done_res    = 1'b1;
      r.size_length = len_size;
      r.total_size  = emitted;
      r.status      = st;
      step_q[step_q.size()-1] = r;
      clear_record();
    end

    foreach (step_q[i]) annexb_q.push_back(step_q[i]);
  endfunction

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
    end
  endfunction

  always @(posedge clk) begin
    annexb_out_t want;
    if (rst) begin
      kind_reg = KIND_AVC;
      clear_record();
      annexb_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) kind_reg = cfg_data;
      if (s_tvalid && s_tready) predict_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (annexb_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, expected none, got tdata %0h tuser %b tlast %b",
                   $time, m_tdata, m_tuser, m_tlast);
        end else begin
          want = annexb_q.pop_front();
          check_field("out_byte", want.out_byte, m_tdata[7:0]);
          check_field("byte_valid", want.byte_valid, m_tuser);
          check_field("done_res", want.done_res, m_tlast);
          check_field("size_length", want.size_length, m_tdata[LEN_LSB +: 3]);
          check_field("total_size", want.total_size, m_tdata[TOTAL_LSB +: SIZE_BITS_DEF]);
          check_field("status", want.status, m_tdata[STAT_LSB +: 2]);
        end
      end
    end
    pending = annexb_q.size();
  end

endmodule

// ----- test/tb_codec_config_to_annexb.sv -----
`timescale 1ns / 1ps

module tb_codec_config_to_annexb;
  import ccta_pkg::*;

  localparam int TDATA_W      = ((SIZE_BITS_DEF + 13 + 7) / 8) * 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_BYTES = 280;
  localparam int PHASES       = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [7:0] SC_ONE = 8'h01;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_data;
  logic               s_tvalid;
  logic               s_tready;
  logic [7:0]         s_tdata;
  logic               s_tlast;
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tuser;
  logic               m_tlast;

  int errors;
  int pending;
  int cycles;
  int sent_bytes;
  int hold_req;
  bit idle_on;

  logic [7:0] rec_q[$];
  logic [1:0] kind_plan[PHASES] = '{KIND_HVC, KIND_AVC, KIND_PASS, KIND_HVC,
                                    2'd3, KIND_AVC, KIND_HVC, KIND_PASS};

  codec_config_to_annexb dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  ccta_checker #(.TDATA_W(TDATA_W)) annexb_chk (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_codec_config_to_annexb NOT OK");
      $finish;
    end
  end

  // result side: per-result stall, plus one long hold-off
  initial begin
    int stall;
    int hold_n;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req > 0) begin
        hold_n = hold_req;
        hold_req = 0;
        m_tready <= 1'b0;
        repeat (hold_n) @(posedge clk);
      end
      stall = idle_on ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sent_bytes++;
  endtask

  task automatic send_record();
    foreach (rec_q[i]) send_byte(rec_q[i], i == rec_q.size() - 1);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_kind(logic [1:0] k);
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic int nal_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
  endfunction

  function automatic void add_nal(int len);
    rec_q.push_back(8'(len >> 8));
    rec_q.push_back(8'(len));
    repeat (len) rec_q.push_back(8'($urandom));
  endfunction

  function automatic void build_avc();
    int n_sps;
    int n_pps;
    rec_q.delete();
    rec_q.push_back(MARKER);
    repeat (4) rec_q.push_back(8'($urandom));  // profile bytes and length size
    n_sps = $urandom_range(0, 3);
    rec_q.push_back({3'($urandom), 5'(n_sps)});
    repeat (n_sps) add_nal(nal_len());
    n_pps = $urandom_range(0, 3);
    rec_q.push_back(8'(n_pps));
    repeat (n_pps) add_nal(nal_len());
  endfunction

  function automatic void build_hvc();
    int n_arr;
    int n_nal;
    rec_q.delete();
    rec_q.push_back(MARKER);
    repeat (21) rec_q.push_back(8'($urandom));  // header bytes and length size
    n_arr = $urandom_range(0, 3);
    rec_q.push_back(8'(n_arr));
    repeat (n_arr) begin
      rec_q.push_back(8'($urandom));
      n_nal = $urandom_range(0, 2);
      rec_q.push_back(8'h00);
      rec_q.push_back(8'(n_nal));
      repeat (n_nal) add_nal(nal_len());
    end
  endfunction

  // damage a well-formed record: overwrite one byte and/or cut it short
  function automatic void corrupt_record();
    int cut;
    if ($urandom_range(0, 1)) rec_q[$urandom_range(1, rec_q.size() - 1)] = 8'($urandom);
    cut = $urandom_range(1, rec_q.size());
    while (rec_q.size() > cut) void'(rec_q.pop_back());
  endfunction

  function automatic void build_unmarked(int max_len);
    int len;
    int at;
    rec_q.delete();
    len = $urandom_range(1, max_len);
    repeat (len) rec_q.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
    if (len >= 3 && $urandom_range(0, 2) != 0) begin
      at = $urandom_range(0, (len - 3 < 4) ? len - 3 : 4);
      rec_q[at]     = 8'h00;
      rec_q[at + 1] = 8'h00;
      rec_q[at + 2] = SC_ONE;
    end
  endfunction

  initial begin
    int phase_bytes;
    int pick;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data  <= KIND_AVC;
    s_tvalid  <= 1'b0;
    s_tdata   <= 8'h00;
    s_tlast   <= 1'b0;
    idle_on   = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed records, codec kind at its reset value, then one in pass-through
    rec_q = '{MARKER};
    send_record();
    rec_q = '{8'h00, 8'h00, SC_ONE, 8'h55};
    send_record();
    rec_q = '{8'h00, 8'h00, SC_ONE};
    send_record();
    // one sps, one empty pps, then a stray trailing byte
    rec_q = '{MARKER, 8'hAA, 8'hBB, 8'hCC, 8'hFF, 8'hE1, 8'h00, 8'h02, 8'h67, 8'h42,
              8'h01, 8'h00, 8'h00, 8'h77};
    send_record();
    rec_q = '{MARKER, 8'h00, 8'h00, 8'h00, 8'hFC, 8'hE1, 8'h00};
    send_record();
    rec_q = '{MARKER, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hE0, 8'h00};
    send_record();
    wait_drained();
    write_kind(KIND_PASS);
    rec_q = '{8'h00, 8'hFF};
    send_record();

    sent_bytes = 0;
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_kind(kind_plan[p]);
      if (p == 1) hold_req = HOLD_CYCLES;
      phase_bytes = sent_bytes;
      while (sent_bytes - phase_bytes < RANDOM_BYTES / PHASES) begin
        idle_on = ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 9);
        if (kind_plan[p] > KIND_HVC) begin
          build_unmarked(10);
        end else if (pick >= 8) begin
          build_unmarked(8);
        end else begin
          if (kind_plan[p] == KIND_AVC) build_avc();
          else build_hvc();
          if (pick >= 6) corrupt_record();
          else if (pick == 5) rec_q.push_back(8'($urandom));
        end
        send_record();
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("tb_codec_config_to_annexb OK");
    end else begin
      $display("tb_codec_config_to_annexb NOT OK");
    end
    $finish;
  end

endmodule
